// File: hw/rtl/bbcl_pkg.sv
`timescale 1ns / 1ps

package bbcl_pkg;

    // Table geometry
    localparam int ENTRIES  = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int ENTRY_W  = 5;
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int STAMP_W  = 32;
    localparam int REF_W    = 8;

    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_PIN     = 2'd2,
        MODE_UNPIN   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_NO_FREE   = 2'd1,
        RC_UNDERFLOW = 2'd2,
        RC_OVERFLOW  = 2'd3
    } res_code_t;

    typedef struct packed {
        mode_t                mode;
        logic [DEV_W-1:0]     device;
        logic [BLK_W-1:0]     block_number;
        logic [STAMP_W-1:0]   now;
        logic [ENTRY_W-1:0]   entry_index;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]   entry;
        logic                 hit;
        logic                 needs_fill;
        logic [REF_W-1:0]     ref_count;
        res_code_t            status;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_get;
        logic scan_done;
    } dp_stat_t;

endpackage

// File: hw/rtl/bbcl_datapath.sv
`timescale 1ns / 1ps

module bbcl_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbcl_pkg::req_t    s_data,
    input  bbcl_pkg::dp_cmd_t cmd,
    output bbcl_pkg::dp_stat_t stat,
    output bbcl_pkg::rsp_t    m_data
);
    import bbcl_pkg::*;

    typedef struct packed {
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   blk;
        logic [STAMP_W-1:0] stamp;
    } rec_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [REF_W-1:0] REF_MAX  = {REF_W{1'b1}};

    // Tag and stamp memory, one read or write per cycle
    rec_t mem [ENTRIES];
    rec_t mem_q_reg;

    // Per-entry state with a defined reset
    logic [ENTRIES-1:0] in_use_reg;
    logic [ENTRIES-1:0] filled_reg;
    logic [REF_W-1:0]   refs_reg [ENTRIES];

    req_t               req_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_vld_reg;
    logic               have_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   pick_reg;
    logic [STAMP_W-1:0] best_reg;
    rsp_t               rsp_reg;

    logic               match;
    logic               free_ent;
    logic [STAMP_W-1:0] stamp_eff;
    logic               is_get;
    logic               oor;
    logic [IDX_W-1:0]   tgt;
    logic [IDX_W-1:0]   sel_idx;
    logic [REF_W-1:0]   sel_refs;
    logic               sel_filled;
    logic               alloc;
    logic               wr_refs;
    logic [REF_W-1:0]   refs_next;
    rsp_t               rsp_next;

    // Compare the entry read in the previous cycle
    always_comb begin
        is_get    = (req_reg.mode == MODE_GET);
        oor       = (32'(req_reg.entry_index) >= ENTRIES);
        tgt       = is_get ? pick_reg : req_reg.entry_index[IDX_W-1:0];
        sel_idx   = cmd.scan ? cmp_idx_reg : tgt;
        sel_refs  = refs_reg[sel_idx];
        sel_filled = filled_reg[sel_idx];
        match     = in_use_reg[cmp_idx_reg] && (mem_q_reg.dev == req_reg.device)
                    && (mem_q_reg.blk == req_reg.block_number);
        stamp_eff = in_use_reg[cmp_idx_reg] ? mem_q_reg.stamp : '0;
        free_ent  = (sel_refs == '0);
    end

    assign stat.in_get    = (s_data.mode == MODE_GET);
    assign stat.scan_done = cmd.scan && cmp_vld_reg && (match || cmp_idx_reg == LAST_IDX);

    // Build the result and the count update for the finishing item
    always_comb begin
        rsp_next = '{entry: ENTRY_W'(tgt), hit: 1'b0, needs_fill: 1'b0,
                     ref_count: '0, status: RC_OK};
        refs_next = sel_refs;
        alloc     = 1'b0;
        wr_refs   = 1'b0;
        if (is_get) begin
            if (hit_reg) begin
                rsp_next.hit        = 1'b1;
                rsp_next.needs_fill = !sel_filled;
                if (sel_refs == REF_MAX) begin
                    rsp_next.status = RC_OVERFLOW;
                end else begin
                    refs_next = REF_W'(sel_refs + 1'b1);
                    wr_refs   = 1'b1;
                end
                rsp_next.ref_count = refs_next;
            end else if (have_reg) begin
                alloc     = 1'b1;
                wr_refs   = 1'b1;
                refs_next = REF_W'(1);
                rsp_next.needs_fill = 1'b1;
                rsp_next.ref_count  = refs_next;
            end else begin
                rsp_next.entry  = '0;
                rsp_next.status = RC_NO_FREE;
            end
        end else begin
            rsp_next.entry = req_reg.entry_index;
            if (!oor) begin
                if (req_reg.mode == MODE_PIN) begin
                    if (sel_refs == REF_MAX) begin
                        rsp_next.status = RC_OVERFLOW;
                    end else begin
                        refs_next = REF_W'(sel_refs + 1'b1);
                        wr_refs   = 1'b1;
                    end
                end else begin
                    if (sel_refs == '0) begin
                        rsp_next.status = RC_UNDERFLOW;
                    end else begin
                        refs_next = REF_W'(sel_refs - 1'b1);
                        wr_refs   = 1'b1;
                    end
                end
                rsp_next.ref_count = refs_next;
            end
        end
    end

    // Memory port: read while scanning, write on allocation
    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            mem_q_reg <= mem[rd_addr_reg];
        end
        if (cmd.commit && alloc) begin
            mem[tgt] <= '{dev: req_reg.device, blk: req_reg.block_number,
                          stamp: req_reg.now};
        end
    end

    // Request capture, scan pointers, best pick and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= s_data;
            rd_addr_reg <= '0;
        end else if (cmd.scan) begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            cmp_idx_reg <= rd_addr_reg;
            if (cmp_vld_reg) begin
                if (match) begin
                    pick_reg <= cmp_idx_reg;
                end else if (free_ent && (!have_reg || stamp_eff < best_reg)) begin
                    pick_reg <= cmp_idx_reg;
                    best_reg <= stamp_eff;
                end
            end
        end
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    // Scan flags and per-entry state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            in_use_reg  <= '0;
            filled_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                refs_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                cmp_vld_reg <= 1'b0;
                have_reg    <= 1'b0;
                hit_reg     <= 1'b0;
            end else if (cmd.scan) begin
                cmp_vld_reg <= 1'b1;
                if (cmp_vld_reg) begin
                    if (match) begin
                        hit_reg <= 1'b1;
                    end else if (free_ent) begin
                        have_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit) begin
                if (wr_refs) begin
                    refs_reg[tgt] <= refs_next;
                end
                if (is_get && (hit_reg || have_reg)) begin
                    filled_reg[tgt] <= 1'b1;
                end
                if (alloc) begin
                    in_use_reg[tgt] <= 1'b1;
                end
            end
        end
    end

    assign m_data = rsp_reg;

endmodule

// File: hw/rtl/bbcl_ctrl.sv
`timescale 1ns / 1ps

module bbcl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  bbcl_pkg::dp_stat_t stat,
    output bbcl_pkg::dp_cmd_t  cmd
);
    import bbcl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // Sequence one item: capture, scan (get only), commit
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_get ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> out_free)
        else $error("commit while result pending");

    // A commit always presents a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("result lost after commit");

    // Scan completion only while scanning
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.scan_done |-> (state_reg == S_SCAN))
        else $error("scan done outside scan");

    // Scan is exclusive with commit and with load
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.scan && (cmd.commit || cmd.load)))
        else $error("conflicting datapath commands");

endmodule

// File: hw/rtl/block_buffer_cache_lookup_core.sv
`timescale 1ns / 1ps
// Sequence: a get scans the table between accept and result, ending early on a hit;
//   release, pin and unpin skip the scan. The commit waits while a result is pending.
// One item at a time; the next beat is taken the cycle after the commit,
//   and the scan, one entry per cycle over the single memory read port,
//   sets the get rate.
// Reset: synchronous active-low aresetn clears in_use, filled and counts at once;
//   tags and stamps need no clearing pass.
module block_buffer_cache_lookup_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bbcl_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bbcl_pkg::rsp_t   m_data
);
    import bbcl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bbcl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bbcl_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bbcl_pkg::*;

    localparam int ITEM_TOTAL  = 1650;
    localparam int CALM_ITEMS  = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 40;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    // Shadow of the cache table plus the queue of predicted lookup results
    class lookup_scoreboard;
        bit               in_use  [ENTRIES];
        bit [DEV_W-1:0]   tag_dev [ENTRIES];
        bit [BLK_W-1:0]   tag_blk [ENTRIES];
        bit [REF_W-1:0]   cnt     [ENTRIES];
        bit               filled  [ENTRIES];
        bit [STAMP_W-1:0] stamp   [ENTRIES];
        rsp_t             outcome_q[$];
        int               errors;

        function new();
            errors = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                in_use[i]  = 1'b0;
                tag_dev[i] = '0;
                tag_blk[i] = '0;
                cnt[i]     = '0;
                filled[i]  = 1'b0;
                stamp[i]   = '0;
            end
        endfunction

        // Apply one request to the shadow table and return its result
        function rsp_t lookup_outcome(req_t r);
            rsp_t o;
            int   pick;
            int   idx;
            o = '0;
            o.status = RC_OK;
            if (r.mode == MODE_GET) begin
                // hit: live entry with the same device and block
                for (int i = 0; i < ENTRIES; i++) begin
                    if (in_use[i] && tag_dev[i] == r.device &&
                        tag_blk[i] == r.block_number) begin
                        o.entry      = ENTRY_W'(i);
                        o.hit        = 1'b1;
                        o.needs_fill = !filled[i];
                        if (cnt[i] == '1) begin
                            o.status = RC_OVERFLOW;
                        end else begin
                            cnt[i] = cnt[i] + 1'b1;
                        end
                        filled[i]   = 1'b1;
                        o.ref_count = cnt[i];
                        return o;
                    end
                end
                // miss: oldest unreferenced entry, lowest index wins a tie
                pick = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (cnt[i] == 0 && (pick < 0 || stamp[i] < stamp[pick])) begin
                        pick = i;
                    end
                end
                if (pick < 0) begin
                    o.status = RC_NO_FREE;
                    return o;
                end
                in_use[pick]  = 1'b1;
                tag_dev[pick] = r.device;
                tag_blk[pick] = r.block_number;
                cnt[pick]     = REF_W'(1);
                stamp[pick]   = r.now;
                filled[pick]  = 1'b1;
                o.entry       = ENTRY_W'(pick);
                o.needs_fill  = 1'b1;
                o.ref_count   = REF_W'(1);
                return o;
            end
            idx     = int'(r.entry_index);
            o.entry = r.entry_index;
            if (idx >= ENTRIES) begin
                return o;
            end
            if (r.mode == MODE_PIN) begin
                if (cnt[idx] == '1) begin
                    o.status = RC_OVERFLOW;
                end else begin
                    cnt[idx] = cnt[idx] + 1'b1;
                end
            end else begin
                if (cnt[idx] == 0) begin
                    o.status = RC_UNDERFLOW;
                end else begin
                    cnt[idx] = cnt[idx] - 1'b1;
                end
            end
            o.ref_count = cnt[idx];
            return o;
        endfunction

        function rsp_t note_request(req_t r);
            rsp_t o;
            o = lookup_outcome(r);
            outcome_q.push_back(o);
            return o;
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (outcome_q.size() == 0) begin
                $error("unexpected result beat: entry %0d status %0d", got.entry, got.status);
                errors++;
                return;
            end
            want = outcome_q.pop_front();
            if (got.entry !== want.entry) begin
                $error("entry: expected %0d, got %0d", want.entry, got.entry);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.needs_fill !== want.needs_fill) begin
                $error("needs_fill: expected %0d, got %0d", want.needs_fill, got.needs_fill);
                errors++;
            end
            if (got.ref_count !== want.ref_count) begin
                $error("ref_count: expected %0d, got %0d", want.ref_count, got.ref_count);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int outstanding();
            return outcome_q.size();
        endfunction
    endclass

    lookup_scoreboard sb = new();

    bit               calm;
    int               items_sent;
    int               idle_cycles;
    bit [STAMP_W-1:0] tick;
    rsp_t             last_outcome;
    bit [DEV_W-1:0]   pool_dev [POOL_SIZE];
    bit [BLK_W-1:0]   pool_blk [POOL_SIZE];

    block_buffer_cache_lookup_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic req_t get_req(bit [DEV_W-1:0] dev, bit [BLK_W-1:0] blk,
                                     bit [STAMP_W-1:0] now);
        req_t r;
        r.mode         = MODE_GET;
        r.device       = dev;
        r.block_number = blk;
        r.now          = now;
        r.entry_index  = ENTRY_W'($urandom);
        return r;
    endfunction

    // Count requests carry junk in the fields they do not use
    function automatic req_t count_req(mode_t m, int idx);
        req_t r;
        r.mode         = m;
        r.device       = DEV_W'($urandom);
        r.block_number = $urandom;
        r.now          = $urandom;
        r.entry_index  = ENTRY_W'(idx);
        return r;
    endfunction

    // Mostly creeping time with repeats, now and then a wild value
    function automatic bit [STAMP_W-1:0] next_now();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom;
        end
        tick = tick + $urandom_range(0, 2);
        return tick;
    endfunction

    // Pick some entry that still holds references, -1 if none
    function automatic int held_entry();
        int start;
        int j;
        start = $urandom_range(0, ENTRIES - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            j = (start + i) % ENTRIES;
            if (sb.cnt[j] != 0) begin
                return j;
            end
        end
        return -1;
    endfunction

    // Present one request beat and hold it until accepted
    task automatic issue(input req_t r);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_outcome = sb.note_request(r);
        items_sent++;
        if (items_sent >= ITEM_TOTAL - CALM_ITEMS) begin
            calm = 1'b1;
        end
    endtask

    // Drop valid and hold off until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Drop every reference so the whole table is free again
    task automatic release_all();
        for (int i = 0; i < ENTRIES; i++) begin
            while (sb.cnt[i] != 0) begin
                issue(count_req(mode_t'($urandom_range(0, 1) ? MODE_RELEASE : MODE_UNPIN), i));
            end
        end
    endtask

    // Ask for more fresh blocks than there are entries, then free them
    task automatic fill_table();
        repeat (ENTRIES + 2) begin
            issue(get_req(DEV_W'($urandom), $urandom, next_now()));
        end
        release_all();
    endtask

    // Drive one entry's count to the top and past it, then down and below zero
    task automatic sweep_count();
        bit [DEV_W-1:0] dev;
        bit [BLK_W-1:0] blk;
        int             e;
        release_all();
        dev = DEV_W'($urandom);
        blk = $urandom;
        issue(get_req(dev, blk, next_now()));
        e = int'(last_outcome.entry);
        while (sb.cnt[e] != '1) begin
            issue(count_req(MODE_PIN, e));
        end
        issue(count_req(MODE_PIN, e));
        issue(get_req(dev, blk, next_now()));
        while (sb.cnt[e] != 0) begin
            issue(count_req(mode_t'($urandom_range(0, 1) ? MODE_RELEASE : MODE_UNPIN), e));
        end
        issue(count_req(MODE_UNPIN, e));
    endtask

    // Typical use: gets over a shared working set, releases and pins of held entries, some noise
    task automatic mixed_traffic(int n);
        int   sel;
        int   p;
        int   e;
        req_t r;
        for (int k = 0; k < n && items_sent < ITEM_TOTAL; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                p = $urandom_range(0, POOL_SIZE - 1);
                issue(get_req(pool_dev[p], pool_blk[p], next_now()));
            end else if (sel < 40) begin
                issue(get_req(DEV_W'($urandom), $urandom, next_now()));
            end else if (sel < 85) begin
                e = held_entry();
                if (e < 0) begin
                    e = $urandom_range(0, ENTRIES - 1);
                end
                issue(count_req(mode_t'(sel < 70 ? MODE_RELEASE : MODE_UNPIN), e));
            end else if (sel < 90) begin
                e = held_entry();
                if (e < 0) begin
                    e = $urandom_range(0, ENTRIES - 1);
                end
                issue(count_req(MODE_PIN, e));
            end else begin
                r.mode         = mode_t'($urandom_range(0, 3));
                r.device       = DEV_W'($urandom);
                r.block_number = $urandom;
                r.now          = $urandom;
                r.entry_index  = ENTRY_W'($urandom);
                issue(r);
            end
        end
    endtask

    // Result side: random stall bursts, none in the closing stretch
    initial begin
        int stall;
        m_ready = 1'b0;
        stall   = 0;
        forever begin
            @(posedge aclk);
            if (!calm && stall == 0 && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 3);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("block_buffer_cache_lookup_core regression: fail");
            $finish;
        end
    end

    initial begin
        bit swept;
        int pick;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        calm        = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        tick        = '0;
        swept       = 1'b0;
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        pool_dev[1] = '1;
        pool_blk[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            pool_dev[i] = DEV_W'($urandom);
            pool_blk[i] = $urandom;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, released hit, underflow paths, ties
        issue(get_req(8'h00, 32'h0000_0000, 32'h0000_0000));
        issue(get_req(8'hff, 32'hffff_ffff, 32'hffff_ffff));
        issue(get_req(8'h00, 32'h0000_0000, 32'd5));
        issue(get_req(8'hff, 32'h0000_0000, 32'd7));
        issue(get_req(8'h00, 32'hffff_ffff, 32'd7));
        issue(count_req(MODE_RELEASE, ENTRIES - 1));
        issue(count_req(MODE_UNPIN, ENTRIES - 1));
        issue(count_req(MODE_PIN, ENTRIES - 1));
        issue(count_req(MODE_UNPIN, ENTRIES - 1));
        issue(count_req(MODE_RELEASE, 0));
        issue(count_req(MODE_RELEASE, 0));
        issue(get_req(8'h00, 32'h0000_0000, 32'd9));
        issue(count_req(MODE_RELEASE, 0));
        issue(count_req(MODE_RELEASE, 1));
        issue(count_req(MODE_RELEASE, 2));
        issue(count_req(MODE_RELEASE, 3));
        issue(get_req(8'h01, 32'h0000_0001, 32'd100));
        issue(get_req(8'h02, 32'h0000_0002, 32'd100));
        issue(count_req(MODE_PIN, 1));
        issue(count_req(MODE_UNPIN, 1));
        wait_drained();

        // Random episodes until the item budget is spent
        while (items_sent < ITEM_TOTAL) begin
            pick = $urandom_range(0, 9);
            if (!swept && items_sent > 400) begin
                sweep_count();
                swept = 1'b1;
            end else if (pick == 0) begin
                fill_table();
            end else begin
                mixed_traffic($urandom_range(40, 80));
            end
            if (pick == 1) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("block_buffer_cache_lookup_core regression: pass");
        end else begin
            $display("block_buffer_cache_lookup_core regression: fail");
        end
        $finish;
    end

endmodule

// File: block_buffer_cache_lookup_core.f
hw/rtl/bbcl_pkg.sv
hw/rtl/bbcl_datapath.sv
hw/rtl/bbcl_ctrl.sv
hw/rtl/block_buffer_cache_lookup_core.sv
tb/sv/testbench.sv
